// ===== rtl/sd_pkg.sv =====
// Package for the segment deframer: payload types, header lengths and result codes.
package sd_pkg;

  localparam int unsigned PKT_HDR_LEN  = 4;
  localparam int unsigned SEG_HDR_LEN  = 20;
  localparam int unsigned SEG_SIZE_END = 4;
  localparam int unsigned SEG_TS_END   = 12;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_LOSS = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        segment_end;
    logic        discont;
    logic [63:0] timestamp;
    logic [63:0] duration;
    logic        credit_error;
  } out_t;

endpackage

// ===== rtl/sd_parse.sv =====
// Packet and segment header parser: holds the framing state and forms at most one result per transfer.
module sd_parse (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  sd_pkg::in_t  item,
  output logic         res_valid,
  output sd_pkg::out_t res
);

  localparam logic [4:0] SegHdrLen  = 5'(sd_pkg::SEG_HDR_LEN);
  localparam logic [4:0] SegSizeEnd = 5'(sd_pkg::SEG_SIZE_END);
  localparam logic [4:0] SegTsEnd   = 5'(sd_pkg::SEG_TS_END);
  localparam logic [15:0] PktHdrLen = 16'(sd_pkg::PKT_HDR_LEN);

  logic [15:0] pkt_byte_index_r, pkt_byte_index_nxt;
  logic [7:0]  offset_high_r, offset_high_nxt;
  logic [15:0] skip_remaining_r, skip_remaining_nxt;
  logic [4:0]  seg_hdr_index_r, seg_hdr_index_nxt;
  logic [31:0] seg_remaining_r, seg_remaining_nxt;
  logic [63:0] seg_timestamp_r, seg_timestamp_nxt;
  logic [63:0] seg_duration_r, seg_duration_nxt;
  logic [15:0] seg_credit_r, seg_credit_nxt;
  logic        lost_flag_r, lost_flag_nxt;
  logic        partial_flag_r, partial_flag_nxt;

  logic [15:0] idx;
  logic [16:0] credit_sum;
  logic [15:0] credit_dec;
  logic        seg_end;

  assign credit_sum = {1'b0, seg_credit_r} + {9'd0, item.data_byte};
  assign credit_dec = (seg_credit_r != 16'd0) ? seg_credit_r - 16'd1 : 16'd0;

  always_comb begin
    pkt_byte_index_nxt = pkt_byte_index_r;
    offset_high_nxt    = offset_high_r;
    skip_remaining_nxt = skip_remaining_r;
    seg_hdr_index_nxt  = seg_hdr_index_r;
    seg_remaining_nxt  = seg_remaining_r;
    seg_timestamp_nxt  = seg_timestamp_r;
    seg_duration_nxt   = seg_duration_r;
    seg_credit_nxt     = seg_credit_r;
    lost_flag_nxt      = lost_flag_r;
    partial_flag_nxt   = partial_flag_r;
    res_valid          = 1'b0;
    res                = '0;
    res.discont        = lost_flag_r;
    idx                = item.packet_start ? 16'd0 : pkt_byte_index_r;
    seg_end            = 1'b0;

    if (item.req_type == sd_pkg::REQ_LOSS) begin
      // A loss in the middle of a segment closes it with a drop result.
      if (partial_flag_r) begin
        res_valid       = 1'b1;
        res.kind        = sd_pkg::KIND_DROP;
        res.segment_end = 1'b1;
        if (seg_hdr_index_r >= SegHdrLen) begin
          res.timestamp = seg_timestamp_r;
          res.duration  = seg_duration_r;
        end
      end
      lost_flag_nxt      = 1'b1;
      partial_flag_nxt   = 1'b0;
      seg_credit_nxt     = 16'd0;
      seg_hdr_index_nxt  = 5'd0;
      seg_remaining_nxt  = 32'd0;
      pkt_byte_index_nxt = 16'd0;
      skip_remaining_nxt = 16'd0;
    end else begin
      if (item.packet_start) begin
        skip_remaining_nxt = 16'd0;
      end
      pkt_byte_index_nxt = (idx != 16'hFFFF) ? idx + 16'd1 : idx;

      if (idx < PktHdrLen) begin
        case (idx[1:0])
          2'd1: offset_high_nxt = item.data_byte;
          2'd2: skip_remaining_nxt = (lost_flag_r && !partial_flag_r)
                                     ? {offset_high_r, item.data_byte} : 16'd0;
          2'd3: seg_credit_nxt = credit_sum[16] ? 16'hFFFF : credit_sum[15:0];
          default: ;
        endcase
      end else if (!item.packet_start && skip_remaining_r != 16'd0) begin
        skip_remaining_nxt = skip_remaining_r - 16'd1;
      end else begin
        partial_flag_nxt = 1'b1;
        if (seg_hdr_index_r < SegHdrLen) begin
          if (seg_hdr_index_r < SegSizeEnd) begin
            seg_remaining_nxt = {seg_remaining_r[23:0], item.data_byte};
          end else if (seg_hdr_index_r < SegTsEnd) begin
            seg_timestamp_nxt = {seg_timestamp_r[55:0], item.data_byte};
          end else begin
            seg_duration_nxt = {seg_duration_r[55:0], item.data_byte};
          end
          seg_hdr_index_nxt = seg_hdr_index_r + 5'd1;
          if (seg_hdr_index_nxt == SegHdrLen && seg_remaining_nxt == 32'd0) begin
            res_valid        = 1'b1;
            res.kind         = sd_pkg::KIND_EMPTY;
            res.segment_end  = 1'b1;
            res.timestamp    = seg_timestamp_nxt;
            res.duration     = seg_duration_nxt;
            res.credit_error = (seg_credit_r == 16'd0);
            seg_end          = 1'b1;
          end
        end else begin
          seg_remaining_nxt = seg_remaining_r - 32'd1;
          res_valid         = 1'b1;
          res.kind          = sd_pkg::KIND_PAYLOAD;
          res.payload_byte  = item.data_byte;
          res.segment_end   = (seg_remaining_r == 32'd1);
          res.timestamp     = seg_timestamp_r;
          res.duration      = seg_duration_r;
          res.credit_error  = (seg_remaining_r == 32'd1) && (seg_credit_r == 16'd0);
          seg_end           = (seg_remaining_r == 32'd1);
        end
        if (seg_end) begin
          seg_credit_nxt    = credit_dec;
          lost_flag_nxt     = 1'b0;
          partial_flag_nxt  = 1'b0;
          seg_hdr_index_nxt = 5'd0;
          seg_remaining_nxt = 32'd0;
        end
      end
    end

    if (!item_valid) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_byte_index_r <= '0;
      offset_high_r    <= '0;
      skip_remaining_r <= '0;
      seg_hdr_index_r  <= '0;
      seg_remaining_r  <= '0;
      seg_timestamp_r  <= '0;
      seg_duration_r   <= '0;
      seg_credit_r     <= '0;
      lost_flag_r      <= 1'b0;
      partial_flag_r   <= 1'b0;
    end else if (item_valid) begin
      pkt_byte_index_r <= pkt_byte_index_nxt;
      offset_high_r    <= offset_high_nxt;
      skip_remaining_r <= skip_remaining_nxt;
      seg_hdr_index_r  <= seg_hdr_index_nxt;
      seg_remaining_r  <= seg_remaining_nxt;
      seg_timestamp_r  <= seg_timestamp_nxt;
      seg_duration_r   <= seg_duration_nxt;
      seg_credit_r     <= seg_credit_nxt;
      lost_flag_r      <= lost_flag_nxt;
      partial_flag_r   <= partial_flag_nxt;
    end
  end

endmodule

// ===== rtl/segment_deframer.sv =====
// Segment deframer top level: input handshake, parser and registered result stage.
//
// Usage: packet bytes and packet-loss events enter on the in_ channel, one per
// transfer, with packet_start marking the first byte of each packet. Each input
// transfer yields at most one result on the out_ channel: a payload byte tagged
// with its segment's timestamp, duration and discontinuity, an empty-segment
// end, or a drop marker when a loss cuts a segment short.
// A result appears on out_valid in the cycle after the input transfer that
// causes it. The block takes one input item per cycle while the receiver does
// not stall; the framing state is updated by one pass of logic per byte and
// results leave through a single output register.
// When the receiver stalls, the output register holds its result and in_ready
// falls only while that register is full and out_ready is low, so a new item
// is taken in the same cycle as the held result leaves.
// Reset (rst_n low, synchronous) empties the output register and clears all
// framing state; the first byte afterwards is read as packet header byte 0.
module segment_deframer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sd_pkg::in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output sd_pkg::out_t out_data
);

  logic         in_xfer;
  logic         res_valid;
  sd_pkg::out_t res;
  logic         out_valid_r, out_valid_nxt;
  sd_pkg::out_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  sd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_xfer),
    .item       (in_data),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/tb.sv =====
// Testbench for segment_deframer: directed table, packetized random streams and a scoreboard.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;

  typedef struct {
    sd_pkg::in_t  stim;
    bit           typed;
    sd_pkg::out_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  sd_pkg::in_t  in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  sd_pkg::out_t out_data;

  always #5 clk = ~clk;

  segment_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Deframer state as the block should hold it.
  logic [15:0] pos = '0;
  logic [7:0]  off_hi = '0;
  logic [15:0] skip_left = '0;
  logic [4:0]  hdr_cnt = '0;
  logic [31:0] seg_left = '0;
  logic [63:0] seg_ts = '0;
  logic [63:0] seg_dur = '0;
  logic [15:0] credit = '0;
  logic        lost = 1'b0;
  logic        partial = 1'b0;

  sd_pkg::out_t pending_results[$];
  row_t         directed[$];

  // Segment stream that random packets are cut from; head and tail mark segment bounds.
  logic [7:0] stream_bytes[$];
  bit         stream_head[$];
  bit         stream_tail[$];

  int send_idle = 14;
  int recv_idle = 59;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int sent = 0;
  int items_taken = 0;
  int results_seen = 0;
  int drops = 0;
  int empties = 0;
  int disconts = 0;
  int over_count = 0;
  int errors = 0;
  int idle_cycles = 0;
  int queued_before;

  function automatic sd_pkg::in_t item_of(input logic req, input logic [7:0] b,
                                          input logic sop);
    sd_pkg::in_t x;
    x.req_type     = req;
    x.data_byte    = b;
    x.packet_start = sop;
    return x;
  endfunction

  task automatic deframe_item(input sd_pkg::in_t x);
    sd_pkg::out_t r;
    logic [15:0]  idx;
    logic [16:0]  sum;
    bit           emit;
    r = '0;
    emit = 1'b0;
    if (x.req_type == sd_pkg::REQ_LOSS) begin
      if (partial) begin
        emit = 1'b1;
        r.kind = sd_pkg::KIND_DROP;
        r.segment_end = 1'b1;
        r.discont = lost;
        if (hdr_cnt >= sd_pkg::SEG_HDR_LEN) begin
          r.timestamp = seg_ts;
          r.duration = seg_dur;
        end
      end
      lost = 1'b1;
      partial = 1'b0;
      credit = '0;
      hdr_cnt = '0;
      seg_left = '0;
      pos = '0;
      skip_left = '0;
    end else begin
      if (x.packet_start) begin
        pos = '0;
        skip_left = '0;
      end
      idx = pos;
      if (pos != 16'hFFFF) pos++;
      if (idx < sd_pkg::PKT_HDR_LEN) begin
        case (idx)
          16'd1: off_hi = x.data_byte;
          16'd2: skip_left = (lost && !partial) ? {off_hi, x.data_byte} : 16'd0;
          16'd3: begin
            sum = {1'b0, credit} + {9'd0, x.data_byte};
            credit = sum[16] ? 16'hFFFF : sum[15:0];
          end
          default: ;
        endcase
      end else if (skip_left != 0) begin
        skip_left--;
      end else begin
        partial = 1'b1;
        if (hdr_cnt < sd_pkg::SEG_HDR_LEN) begin
          if (hdr_cnt < sd_pkg::SEG_SIZE_END) seg_left = {seg_left[23:0], x.data_byte};
          else if (hdr_cnt < sd_pkg::SEG_TS_END) seg_ts = {seg_ts[55:0], x.data_byte};
          else seg_dur = {seg_dur[55:0], x.data_byte};
          hdr_cnt++;
          if (hdr_cnt == sd_pkg::SEG_HDR_LEN && seg_left == 0) begin
            emit = 1'b1;
            r.kind = sd_pkg::KIND_EMPTY;
            r.segment_end = 1'b1;
          end
        end else begin
          seg_left--;
          emit = 1'b1;
          r.kind = sd_pkg::KIND_PAYLOAD;
          r.payload_byte = x.data_byte;
          r.segment_end = (seg_left == 0);
        end
        if (emit) begin
          r.discont = lost;
          r.timestamp = seg_ts;
          r.duration = seg_dur;
          r.credit_error = r.segment_end && (credit == 0);
          if (r.segment_end) begin
            if (credit != 0) credit--;
            lost = 1'b0;
            partial = 1'b0;
            hdr_cnt = '0;
            seg_left = '0;
          end
        end
      end
    end
    if (emit) pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] w, input logic [63:0] g);
    if (g !== w) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, w, g);
    end
  endtask

  task automatic check_result(input sd_pkg::out_t got);
    sd_pkg::out_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 64'(want.kind), 64'(got.kind));
      check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
      check_field("segment_end", 64'(want.segment_end), 64'(got.segment_end));
      check_field("discont", 64'(want.discont), 64'(got.discont));
      check_field("timestamp", want.timestamp, got.timestamp);
      check_field("duration", want.duration, got.duration);
      check_field("credit_error", 64'(want.credit_error), 64'(got.credit_error));
      if (want.kind == sd_pkg::KIND_DROP) drops++;
      if (want.kind == sd_pkg::KIND_EMPTY) empties++;
      if (want.discont) disconts++;
      if (want.credit_error) over_count++;
    end
  endtask

  // Predict on every input transfer, check every output transfer, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        queued_before = pending_results.size();
        deframe_item(in_data);
        if (items_taken < directed.size() && directed[items_taken].typed) begin
          if (pending_results.size() > queued_before) void'(pending_results.pop_back());
          pending_results.push_back(directed[items_taken].want);
        end
        items_taken++;
      end
      if (out_valid && out_ready) check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("segment_deframer test failed");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input sd_pkg::in_t x);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0: return 64'hFFFF_FFFF_FFFF_FFFF;
      1: return 64'd0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_segment(input logic [31:0] size);
    logic [159:0] hdr;
    hdr = {size, pick_word(), pick_word()};
    for (int i = 0; i < sd_pkg::SEG_HDR_LEN; i++) begin
      stream_bytes.push_back(hdr[159 - 8 * i -: 8]);
      stream_head.push_back(i == 0);
      stream_tail.push_back(i == sd_pkg::SEG_HDR_LEN - 1 && size == 0);
    end
    for (int unsigned i = 0; i < size; i++) begin
      stream_bytes.push_back(8'($urandom_range(255)));
      stream_head.push_back(1'b0);
      stream_tail.push_back(i == size - 1);
    end
  endtask

  task automatic add_random_segment();
    case ($urandom_range(19))
      0, 1, 2: add_segment(32'd0);
      3, 4:    add_segment(32'($urandom_range(200, 25)));
      default: add_segment(32'($urandom_range(24, 1)));
    endcase
  endtask

  // Cuts n stream bytes into one packet. A lost packet is replaced by a loss event,
  // so the next packet has to resync on its offset.
  task automatic send_packet(input int n, input bit lose, input int count_force);
    logic [7:0]  chunk[$];
    int          first_head;
    int          tails;
    logic [15:0] offset;
    logic [7:0]  count;
    bit          sop;
    first_head = -1;
    tails = 0;
    while (stream_bytes.size() < n) add_random_segment();
    for (int i = 0; i < n; i++) begin
      chunk.push_back(stream_bytes.pop_front());
      if (stream_head.pop_front() && first_head < 0) first_head = i;
      if (stream_tail.pop_front()) tails++;
    end
    if (lose) begin
      send_item(item_of(sd_pkg::REQ_LOSS, 8'($urandom_range(255)), 1'($urandom_range(1))));
    end else begin
      if ($urandom_range(9) == 0) offset = 16'($urandom_range(16'hFFFF));
      else if (first_head >= 0) offset = 16'(first_head);
      else if ($urandom_range(3) == 0) offset = 16'hFFFF;
      else offset = 16'(n + $urandom_range(30));
      if (count_force >= 0) count = 8'(count_force);
      else if ($urandom_range(9) == 0) count = 8'($urandom_range(255));
      else count = (tails > 255) ? 8'hFF : 8'(tails);
      // Packets with a forced count always mark their start so the count lands.
      sop = (count_force >= 0) || ($urandom_range(29) != 0);
      send_item(item_of(sd_pkg::REQ_BYTE, 8'($urandom_range(255)), sop));
      send_item(item_of(sd_pkg::REQ_BYTE, offset[15:8], 1'b0));
      send_item(item_of(sd_pkg::REQ_BYTE, offset[7:0], 1'b0));
      send_item(item_of(sd_pkg::REQ_BYTE, count, 1'b0));
      foreach (chunk[i]) send_item(item_of(sd_pkg::REQ_BYTE, chunk[i], 1'b0));
    end
  endtask

  task automatic random_traffic(input int target);
    int stop;
    stop = sent + target;
    while (sent < stop) begin
      case ($urandom_range(19))
        0: send_item(item_of(1'($urandom_range(1)), 8'($urandom_range(255)),
                             1'($urandom_range(1))));
        1: send_packet(int'($urandom_range(40, 1)), 1'b1, -1);
        2: send_item(item_of(sd_pkg::REQ_LOSS, 8'($urandom_range(255)),
                             1'($urandom_range(1))));
        default: send_packet(int'($urandom_range(48, 0)), 1'b0, -1);
      endcase
    end
  endtask

  task automatic add_row(input sd_pkg::in_t stim, input bit typed = 1'b0,
                         input sd_pkg::out_t want = '0);
    row_t r;
    r.stim = stim;
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endtask

  initial begin
    // Loss straight after reset, then a packet whose offset skips two bytes onto an
    // empty segment, then a loss that cuts the next segment header short.
    add_row(item_of(sd_pkg::REQ_LOSS, 8'hFF, 1'b1));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'hFF, 1'b1));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'h00, 1'b0));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'h02, 1'b0));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'hFF, 1'b0));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'hAA, 1'b0));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'h55, 1'b0));
    repeat (4) add_row(item_of(sd_pkg::REQ_BYTE, 8'h00, 1'b0));
    repeat (8) add_row(item_of(sd_pkg::REQ_BYTE, 8'hFF, 1'b0));
    repeat (7) add_row(item_of(sd_pkg::REQ_BYTE, 8'h00, 1'b0));
    add_row(item_of(sd_pkg::REQ_BYTE, 8'h01, 1'b0), 1'b1,
            '{kind: sd_pkg::KIND_EMPTY, payload_byte: 8'h00, segment_end: 1'b1,
              discont: 1'b1, timestamp: 64'hFFFF_FFFF_FFFF_FFFF, duration: 64'd1,
              credit_error: 1'b0});
    add_row(item_of(sd_pkg::REQ_BYTE, 8'h00, 1'b0));
    add_row(item_of(sd_pkg::REQ_LOSS, 8'h00, 1'b0), 1'b1,
            '{kind: sd_pkg::KIND_DROP, payload_byte: 8'h00, segment_end: 1'b1,
              discont: 1'b0, timestamp: 64'd0, duration: 64'd0, credit_error: 1'b0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].stim);
    random_traffic(170);
    hold_requests++;
    random_traffic(170);
    drain();

    send_idle = 59;
    recv_idle = 14;
    random_traffic(170);
    drain();

    send_idle = 0;
    recv_idle = 0;
    // Enough header-only packets announcing 255 segments to saturate the count.
    repeat (258) send_packet(0, 1'b0, 255);
    hold_requests++;
    random_traffic(50);
    drain();

    $display("Covered %0d input transfers and %0d results, with saturated segment credit.",
             sent, results_seen);
    $display("Seen: %0d dropped segments, %0d empty segments, %0d discontinuous, %0d over count.",
             drops, empties, disconts, over_count);
    if (errors == 0) begin
      $display("segment_deframer test passed");
    end else begin
      $display("segment_deframer test failed");
    end
    $finish;
  end

endmodule

// ===== segment_deframer.f =====
rtl/sd_pkg.sv
rtl/sd_parse.sv
rtl/segment_deframer.sv
sim/tb.sv
